>>> design/isq_pkg.sv
// shared types and constants for the indexed sequence store
`default_nettype none
package isq_pkg;

  // number of entries the store can hold
  localparam int CAPACITY = 256;
  // width of a cell index and of the entry count
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // fixed field widths
  localparam int KIND_W = 3;
  localparam int POS_W  = 9;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 9;
  // width used for position and count compares
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  // cells per read-gather group
  localparam int GROUP  = 16;
  localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

  // value returned by a read outside the sequence
  localparam logic signed [DATA_W-1:0] READ_FAIL = -32'sd1;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_READ = 3'd0,
    KIND_HEAD = 3'd1,
    KIND_TAIL = 3'd2,
    KIND_AT   = 3'd3,
    KIND_DEL  = 3'd4
  } kind_t;

  // operation broadcast along the row of cells
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } cell_op_t;

  // control broadcast to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] val;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> design/indexed_sequence_store_unit.sv
// top level of the indexed sequence store: request decode, cell row, result register
// Ordered store of up to CAPACITY signed 32-bit values held in a row of cells, one
// value per cell. Inserts shift the row up by one and deletes shift it down, every
// cell taking its neighbor's value at once; reads gather the addressed cell's
// value through a two-level registered or-tree. Each item holds the input side
// through the accepting cycle, the cell update and first gather level (S_EXEC)
// and the second gather level (S_GATHER). The result register loads as S_GATHER
// ends, so a new item is taken only after the previous result is loaded; a stalled
// result holds the next item in S_GATHER, its second gather level, and
// the input stays stalled until that result register frees up. One result is given
// per item, with the value read (-1 for a read outside the sequence, 0 for other
// kinds), an applied flag and the length after the request. No clearing pass is
// needed after reset: only the length is cleared. The input is stalled during reset.
`default_nettype none
module indexed_sequence_store_unit
  import isq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [KIND_W-1:0]        kind,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      read_value,
  output logic                          applied,
  output logic [LEN_W-1:0]              length
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_GATHER = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [KIND_W-1:0] req_kind;
  logic [POS_W-1:0]  req_pos;
  logic [DATA_W-1:0] req_val;
  logic              res_applied;
  logic              res_is_read;
  logic              res_rd_ok;

  logic [CMP_W-1:0]  pos_ext, cnt_ext, ins_pos;
  logic              full, ins_ok, in_range;
  logic              accept, out_free;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd [CAPACITY];
  logic [DATA_W-1:0] gathered;

  assign accept   = in_valid && !in_stall;
  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // request checks against the current length
  always_comb begin
    pos_ext  = CMP_W'(req_pos);
    cnt_ext  = CMP_W'(count);
    full     = (count == CNT_W'(CAPACITY));
    in_range = (pos_ext < cnt_ext);
    ins_pos  = pos_ext;
    unique case (req_kind)
      KIND_HEAD: ins_pos = '0;
      KIND_TAIL: ins_pos = cnt_ext;
      default:   ins_pos = pos_ext;
    endcase
    ins_ok = !full && (ins_pos <= cnt_ext);
  end

  // control broadcast to the cell row
  always_comb begin
    ctrl.op  = OP_NONE;
    ctrl.pos = IDX_W'(req_pos);
    ctrl.val = req_val;
    if (state == S_EXEC) begin
      unique case (req_kind)
        KIND_HEAD, KIND_TAIL, KIND_AT: begin
          if (ins_ok) begin
            ctrl.op  = OP_INS;
            ctrl.pos = IDX_W'(ins_pos);
          end
        end
        KIND_DEL: begin
          if (in_range) begin
            ctrl.op = OP_DEL;
          end
        end
        default: ctrl.op = OP_NONE;
      endcase
    end
  end

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    isq_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .read_data  (cell_rd[i])
    );
  end

  isq_gather u_gather (
    .clk      (clk),
    .capture  (state == S_EXEC),
    .cell_rd  (cell_rd),
    .gathered (gathered)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_EXEC;
      S_EXEC:   state_next = S_GATHER;
      S_GATHER: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      req_pos  <= position;
      req_val  <= value;
    end
  end

  // length update and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_EXEC) begin
      if (ctrl.op == OP_INS) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.op == OP_DEL) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_applied <= (ctrl.op != OP_NONE) || (req_kind == KIND_READ && in_range);
      res_is_read <= (req_kind == KIND_READ);
      res_rd_ok   <= in_range;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_GATHER && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_GATHER && out_free) begin
      applied <= res_applied;
      length  <= LEN_W'(count);
      if (!res_is_read) begin
        read_value <= '0;
      end else if (res_rd_ok) begin
        read_value <= gathered;
      end else begin
        read_value <= READ_FAIL;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/isq_cell.sv
// one storage cell of the sequence row
`default_nettype none
module isq_cell
  import isq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  output logic      [DATA_W-1:0] data,
  output logic      [DATA_W-1:0] read_data
);

  logic [DATA_W-1:0] data_next;

  // shift up on insert, shift down on delete, else hold
  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      OP_INS: begin
        if (idx == ctrl.pos) begin
          data_next = ctrl.val;
        end else if (idx > ctrl.pos) begin
          data_next = left_data;
        end
      end
      OP_DEL: begin
        if (idx >= ctrl.pos) begin
          data_next = right_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // drive own value onto the gather path when addressed
  assign read_data = (idx == ctrl.pos) ? data : '0;

endmodule
`default_nettype wire

>>> design/isq_gather.sv
// or-gather of addressed cell values, two levels, the first one registered
`default_nettype none
module isq_gather
  import isq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              capture,
  input  wire logic [DATA_W-1:0] cell_rd [CAPACITY],
  output logic      [DATA_W-1:0] gathered
);

  logic [DATA_W-1:0] group_or [NGROUP];
  logic [DATA_W-1:0] group_or_next [NGROUP];

  // first level: or within each group of cells
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      group_or_next[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < CAPACITY) begin
          group_or_next[g] = group_or_next[g] | cell_rd[g * GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      group_or <= group_or_next;
    end
  end

  // second level: or across the group results
  always_comb begin
    gathered = '0;
    for (int g = 0; g < NGROUP; g++) begin
      gathered = gathered | group_or[g];
    end
  end

endmodule
`default_nettype wire
